>>> hw/rtl/qfr_pkg.sv
// Shared constants for the quaternion frame rotation unit.
package qfr_pkg;

    localparam int VECTOR_BITS_DEF        = 24;
    localparam int QUAT_FRACTION_BITS_DEF = 14;

    // Direction command carried in tuser.
    localparam logic CMD_BODY_TO_EARTH = 1'b0;
    localparam logic CMD_EARTH_TO_BODY = 1'b1;

endpackage

>>> hw/rtl/quaternion_frame_rotation_unit.sv
// Quaternion frame rotation unit: five-stage pipeline that rotates a 3-vector by a quaternion.
//
//  channel  direction  tdata (low bit up)                         tuser
//  s_       in         quat_w quat_x quat_y quat_z vec_x vec_y vec_z  cmd
//  m_       out        out_x out_y out_z                          saturated
//
// An accepted item passes through the stage registers below in order and is then a valid result;
// one item is taken every cycle while the output is not held. The stages are:
// quaternion products, matrix build and transpose select, matrix by vector products,
// row sums with rounding, saturation.
// Each stage has its own valid bit and moves when it is empty or the next one
// moves, so bubbles close up under a stall and nothing is lost or repeated.
// aresetn clears only the valid bits.
module quaternion_frame_rotation_unit
    import qfr_pkg::*;
#(
    parameter int VECTOR_BITS        = VECTOR_BITS_DEF,
    parameter int QUAT_FRACTION_BITS = QUAT_FRACTION_BITS_DEF,
    localparam int QB     = QUAT_FRACTION_BITS + 2,
    localparam int IN_W   = ((4 * QB + 3 * VECTOR_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((3 * VECTOR_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    input  logic [0:0]       s_tuser,   // cmd

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // out_x, out_y, out_z
    output logic [0:0]       m_tuser    // saturated
);

    localparam int VB  = VECTOR_BITS;
    localparam int FS  = 2 * QUAT_FRACTION_BITS;   // fraction bits of all products
    localparam int PW  = 2 * QB;                   // quaternion product width
    localparam int ME  = 2 * QB + 2;               // matrix element width
    localparam int PRW = ME + VB;                  // element times vector width
    localparam int AW  = PRW + 2;                  // row sum width
    localparam int RW  = AW - FS;                  // rounded row sum width

    localparam logic signed [ME-1:0] ONE  = ME'(1) << FS;
    localparam logic signed [AW-1:0] HALF = AW'(1) << (FS - 1);
    localparam logic [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

    // Stage valid bits and enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !v5_reg || m_tready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: the nine quaternion products.
    logic signed [QB-1:0] qw, qx, qy, qz;
    logic signed [VB-1:0] vec_in [3];

    assign qw = s_tdata[QB-1:0];
    assign qx = s_tdata[2*QB-1:QB];
    assign qy = s_tdata[3*QB-1:2*QB];
    assign qz = s_tdata[4*QB-1:3*QB];
    assign vec_in[0] = s_tdata[4*QB+VB-1:4*QB];
    assign vec_in[1] = s_tdata[4*QB+2*VB-1:4*QB+VB];
    assign vec_in[2] = s_tdata[4*QB+3*VB-1:4*QB+2*VB];

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [VB-1:0] vec1_reg [3];
    logic                 cmd1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            xx_reg   <= PW'(qx) * PW'(qx);
            yy_reg   <= PW'(qy) * PW'(qy);
            zz_reg   <= PW'(qz) * PW'(qz);
            xy_reg   <= PW'(qx) * PW'(qy);
            xz_reg   <= PW'(qx) * PW'(qz);
            yz_reg   <= PW'(qy) * PW'(qz);
            wx_reg   <= PW'(qw) * PW'(qx);
            wy_reg   <= PW'(qw) * PW'(qy);
            wz_reg   <= PW'(qw) * PW'(qz);
            vec1_reg <= vec_in;
            cmd1_reg <= s_tuser[0];
        end
    end

    // Stage 2: rotation matrix, transposed for the earth to body direction.
    logic signed [ME-1:0] xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;
    logic signed [ME-1:0] mat [3][3];
    logic signed [ME-1:0] elem_next [3][3];
    logic signed [ME-1:0] elem_reg  [3][3];
    logic signed [VB-1:0] vec2_reg  [3];

    assign xx_e = ME'(xx_reg);
    assign yy_e = ME'(yy_reg);
    assign zz_e = ME'(zz_reg);
    assign xy_e = ME'(xy_reg);
    assign xz_e = ME'(xz_reg);
    assign yz_e = ME'(yz_reg);
    assign wx_e = ME'(wx_reg);
    assign wy_e = ME'(wy_reg);
    assign wz_e = ME'(wz_reg);

    always_comb begin
        mat[0][0] = ONE - ((yy_e + zz_e) <<< 1);
        mat[0][1] = (xy_e - wz_e) <<< 1;
        mat[0][2] = (xz_e + wy_e) <<< 1;
        mat[1][0] = (xy_e + wz_e) <<< 1;
        mat[1][1] = ONE - ((xx_e + zz_e) <<< 1);
        mat[1][2] = (yz_e - wx_e) <<< 1;
        mat[2][0] = (xz_e - wy_e) <<< 1;
        mat[2][1] = (yz_e + wx_e) <<< 1;
        mat[2][2] = ONE - ((xx_e + yy_e) <<< 1);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                elem_next[i][j] = (cmd1_reg == CMD_EARTH_TO_BODY) ? mat[j][i] : mat[i][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            elem_reg <= elem_next;
            vec2_reg <= vec1_reg;
        end
    end

    // Stage 3: element by vector products.
    logic signed [PRW-1:0] prod_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= PRW'(elem_reg[i][j]) * PRW'(vec2_reg[j]);
                end
            end
        end
    end

    // Stage 4: row sums plus the rounding half.
    logic signed [AW-1:0] acc_reg [3];

    always_ff @(posedge aclk) begin
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= AW'(prod_reg[i][0]) + AW'(prod_reg[i][1])
                            + AW'(prod_reg[i][2]) + HALF;
            end
        end
    end

    // Stage 5: drop the fraction bits and saturate to the vector width.
    logic [RW-1:0]   rnd [3];
    logic [VB-1:0]   sat_val [3];
    logic [2:0]      clip;
    logic [VB-1:0]   out_reg [3];
    logic            sat_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = acc_reg[i][AW-1:FS];
            // The value fits when every bit above the result's sign bit matches it.
            if ((&rnd[i][RW-1:VB-1]) || !(|rnd[i][RW-1:VB-1])) begin
                sat_val[i] = rnd[i][VB-1:0];
                clip[i]    = 1'b0;
            end else begin
                sat_val[i] = rnd[i][RW-1] ? VMIN : VMAX;
                clip[i]    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            out_reg <= sat_val;
            sat_reg <= |clip;
        end
    end

    assign m_tvalid   = v5_reg;
    assign m_tdata    = OUT_W'({out_reg[2], out_reg[1], out_reg[0]});
    assign m_tuser[0] = sat_reg;

`ifndef ASSERT_OFF
    // A saturated result has at least one component pinned at a range limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && sat_reg) |->
            (out_reg[0] == VMAX || out_reg[0] == VMIN || out_reg[1] == VMAX ||
             out_reg[1] == VMIN || out_reg[2] == VMAX || out_reg[2] == VMIN))
        else $error("saturated flag without a clipped component");

    // The input side only stalls when every stage is full and the output is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && m_tvalid && !m_tready))
        else $error("input stalled while the pipeline has room");

    // A result only appears when the sum stage held an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v4_reg))
        else $error("result valid without an item in the sum stage");
`endif

endmodule
